// ===== rtl/ons_pkg.sv =====
// Package for octave_noise_sum: payload structs, register indexes,
// hash constants and pipeline sizing. No dependencies.
`default_nettype none

package ons_pkg;

	localparam int MAX_OCTAVES = 8;
	localparam int OCT_W       = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1;
	localparam int CNT_W       = $clog2(MAX_OCTAVES + 1);
	localparam int SUM_LEVELS  = $clog2(MAX_OCTAVES + 1);
	localparam int SUM_LEAVES  = 2 ** SUM_LEVELS;
	localparam int TERM_W      = 34;
	localparam int ACC_W       = TERM_W + SUM_LEVELS;

	localparam int CFG_IDX_W = 4;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE_X     = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y     = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X    = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y    = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_HEIGHT = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_AMP   = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_PERSISTENCE = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_OCTAVES     = 4'd7;

	localparam logic [16:0] PERS_ONE = 17'd65536;

	localparam logic [31:0] HASH_MUL_Y = 32'd57;
	localparam int          HASH_SHIFT = 13;
	localparam logic [31:0] HASH_C1    = 32'd15731;
	localparam logic [31:0] HASH_C2    = 32'd789221;
	localparam logic [31:0] HASH_C3    = 32'd1376312589;
	localparam logic [31:0] NOISE_ONE  = 32'h4000_0000;

	localparam logic [31:0] HEIGHT_MAX = 32'h7fff_ffff;
	localparam logic [31:0] HEIGHT_MIN = 32'h8000_0000;

	typedef logic signed [31:0] amp_t;
	typedef amp_t [MAX_OCTAVES-1:0] amp_vec_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
	} sample_t;

	typedef struct packed {
		logic signed [31:0] height;
		logic               clipped;
	} result_t;

endpackage

`default_nettype wire

// ===== rtl/ons_hash.sv =====
// Five-stage integer hash lane: octave lattice point to Q2.30 noise.
// Depends on ons_pkg.
`default_nettype none

module ons_hash (
	input  wire logic               clk,
	input  wire logic        [31:0] ix,
	input  wire logic        [31:0] iy,
	output logic signed      [31:0] noise
);
	import ons_pkg::*;

	logic [31:0] n;
	logic [31:0] m_s4, m_s5, m_s6;
	logic [31:0] mm_s5;
	logic [31:0] t_s6;
	logic [31:0] u_s7;
	logic [31:0] v;
	logic signed [31:0] noise_s8;

	assign n = ix + iy * HASH_MUL_Y;
	assign v = (u_s7 + HASH_C3) & 32'h7fff_ffff;

	always_ff @(posedge clk) begin
		m_s4     <= (n << HASH_SHIFT) ^ n;
		mm_s5    <= m_s4 * m_s4;
		m_s5     <= m_s4;
		t_s6     <= mm_s5 * HASH_C1 + HASH_C2;
		m_s6     <= m_s5;
		u_s7     <= m_s6 * t_s6;
		noise_s8 <= $signed(NOISE_ONE - v);
	end

	assign noise = noise_s8;

endmodule

`default_nettype wire

// ===== rtl/ons_amp_table.sv =====
// Per-octave amplitude table, rebuilt one octave per cycle after reset
// and after each register write. Depends on ons_pkg.
`default_nettype none

module ons_amp_table (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  restart,
	input  wire logic signed [31:0]    first_amplitude,
	input  wire logic        [16:0]    persistence,
	output ons_pkg::amp_vec_t          amp,
	output logic                       busy
);
	import ons_pkg::*;

	logic [CNT_W-1:0] cnt_q;
	logic signed [31:0] cur_q;
	amp_vec_t amp_q;
	logic [16:0] pers_c;
	logic signed [49:0] prod;
	logic signed [31:0] next_amp;

	assign busy     = cnt_q != CNT_W'(MAX_OCTAVES);
	assign pers_c   = (persistence > PERS_ONE) ? PERS_ONE : persistence;
	assign prod     = cur_q * $signed({1'b0, pers_c});
	assign next_amp = (cnt_q == '0) ? first_amplitude : prod[47:16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (restart) begin
			cnt_q <= '0;
		end else if (busy) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (busy && !restart) begin
			amp_q[cnt_q[OCT_W-1:0]] <= next_amp;
			cur_q                   <= next_amp;
		end
	end

	assign amp = amp_q;

endmodule

`default_nettype wire

// ===== rtl/octave_noise_sum.sv =====
// Top level of octave_noise_sum: registers, scaling, octave lanes, sum tree.
// Depends on ons_pkg, ons_hash and ons_amp_table.
//
// One sample is taken per clock whenever busy is low, and its result shows
// on result with done high for one cycle once it has passed the scaling,
// lattice, hash, term, sum tree and output registers. The receiver cannot
// stall the pipeline. busy is high after reset and after every register
// write, while the amplitude table is rebuilt through its single
// multiplier; register writes are always taken (cfg_ready is high) and are
// to be made only when no sample is in flight.
`default_nettype none

module octave_noise_sum (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	output logic                                busy,
	input  wire ons_pkg::sample_t               sample,
	output logic                                done,
	output ons_pkg::result_t                    result,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [ons_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [31:0]                    cfg_data
);
	import ons_pkg::*;

	localparam int LATENCY = 10 + SUM_LEVELS;

	logic signed [31:0] scale_x_q, scale_y_q, offset_x_q, offset_y_q;
	logic signed [31:0] base_height_q, first_amp_q;
	logic [16:0] persistence_q;
	logic [3:0]  octave_count_q;
	logic cfg_write;
	amp_vec_t amp;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;
	logic [SUM_LEVELS:1] tv_s;
	logic done_q;
	result_t result_q;

	logic signed [63:0] prod_x_s1, prod_y_s1;
	logic signed [63:0] sx_s2, sy_s2;
	logic [31:0] ix_s3 [MAX_OCTAVES];
	logic [31:0] iy_s3 [MAX_OCTAVES];
	logic signed [31:0] noise_s8 [MAX_OCTAVES];
	logic signed [63:0] tprod [MAX_OCTAVES];
	logic signed [TERM_W-1:0] term_s9 [MAX_OCTAVES];
	logic signed [ACC_W-1:0] leaf [SUM_LEAVES];
	logic signed [ACC_W-1:0] node_s [1:SUM_LEAVES-1];
	logic signed [ACC_W-1:0] root;
	logic in_range;

	assign cfg_ready = 1'b1;
	assign cfg_write = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_x_q      <= 32'sd65536;
			scale_y_q      <= 32'sd65536;
			offset_x_q     <= '0;
			offset_y_q     <= '0;
			base_height_q  <= '0;
			first_amp_q    <= 32'sd65536;
			persistence_q  <= 17'd32768;
			octave_count_q <= 4'd1;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_SCALE_X:     scale_x_q      <= $signed(cfg_data);
				REG_SCALE_Y:     scale_y_q      <= $signed(cfg_data);
				REG_OFFSET_X:    offset_x_q     <= $signed(cfg_data);
				REG_OFFSET_Y:    offset_y_q     <= $signed(cfg_data);
				REG_BASE_HEIGHT: base_height_q  <= $signed(cfg_data);
				REG_FIRST_AMP:   first_amp_q    <= $signed(cfg_data);
				REG_PERSISTENCE: persistence_q  <= cfg_data[16:0];
				REG_OCTAVES:     octave_count_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	ons_amp_table u_amp (
		.clk             (clk),
		.arst_n          (arst_n),
		.restart         (cfg_write),
		.first_amplitude (first_amp_q),
		.persistence     (persistence_q),
		.amp             (amp),
		.busy            (busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			v_s5   <= 1'b0;
			v_s6   <= 1'b0;
			v_s7   <= 1'b0;
			v_s8   <= 1'b0;
			v_s9   <= 1'b0;
			tv_s   <= '0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= start && !busy;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			v_s4   <= v_s3;
			v_s5   <= v_s4;
			v_s6   <= v_s5;
			v_s7   <= v_s6;
			v_s8   <= v_s7;
			v_s9   <= v_s8;
			tv_s   <= {tv_s[SUM_LEVELS-1:1], v_s9};
			done_q <= tv_s[SUM_LEVELS];
		end
	end

	// start position in Q32.32
	always_ff @(posedge clk) begin
		prod_x_s1 <= sample.pos_x * scale_x_q;
		prod_y_s1 <= sample.pos_y * scale_y_q;
		sx_s2     <= prod_x_s1 + (64'(offset_x_q) <<< 16);
		sy_s2     <= prod_y_s1 + (64'(offset_y_q) <<< 16);
	end

	for (genvar k = 0; k < MAX_OCTAVES; k++) begin : g_lane
		localparam int SH = 32 - k;
		localparam logic [63:0] RND = (64'd1 << SH) - 64'd1;
		logic signed [63:0] rx, ry;

		// truncate toward zero: bias negatives before the shift
		assign rx = sx_s2 + $signed(sx_s2[63] ? RND : 64'd0);
		assign ry = sy_s2 + $signed(sy_s2[63] ? RND : 64'd0);

		always_ff @(posedge clk) begin
			ix_s3[k] <= 32'(rx >>> SH);
			iy_s3[k] <= 32'(ry >>> SH);
		end

		ons_hash u_hash (
			.clk   (clk),
			.ix    (ix_s3[k]),
			.iy    (iy_s3[k]),
			.noise (noise_s8[k])
		);

		assign tprod[k] = noise_s8[k] * $signed(amp[k]);

		always_ff @(posedge clk) begin
			term_s9[k] <= (int'(octave_count_q) > k) ? tprod[k][63:30] : '0;
		end
	end

	always_comb begin
		for (int i = 0; i < SUM_LEAVES; i++) begin
			if (i == 0) begin
				leaf[i] = ACC_W'(base_height_q);
			end else if (i <= MAX_OCTAVES) begin
				leaf[i] = ACC_W'(term_s9[i-1]);
			end else begin
				leaf[i] = '0;
			end
		end
	end

	for (genvar n = 1; n < SUM_LEAVES; n++) begin : g_node
		if (2 * n >= SUM_LEAVES) begin : g_bottom
			always_ff @(posedge clk) begin
				node_s[n] <= leaf[2*n-SUM_LEAVES] + leaf[2*n+1-SUM_LEAVES];
			end
		end else begin : g_inner
			always_ff @(posedge clk) begin
				node_s[n] <= node_s[2*n] + node_s[2*n+1];
			end
		end
	end

	assign root     = node_s[1];
	assign in_range = (&root[ACC_W-1:31]) || !(|root[ACC_W-1:31]);

	always_ff @(posedge clk) begin
		if (in_range) begin
			result_q.height  <= $signed(root[31:0]);
			result_q.clipped <= 1'b0;
		end else begin
			result_q.height  <= $signed(root[ACC_W-1] ? HEIGHT_MIN : HEIGHT_MAX);
			result_q.clipped <= 1'b1;
		end
	end

	assign done   = done_q;
	assign result = result_q;

`ifndef SYNTHESIS
	a_done_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without matching transfer");

	a_clip_value: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.clipped |->
			(result.height == $signed(HEIGHT_MAX)) || (result.height == $signed(HEIGHT_MIN)))
		else $error("clipped height not at a limit");

	a_cfg_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> busy)
		else $error("amplitude table not rebuilt after write");
`endif

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for octave_noise_sum: drives samples and register
// writes, predicts each height in-house and checks every done transfer.
// Depends on ons_pkg and the octave_noise_sum RTL.
`default_nettype none

module tb;
	import ons_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = 4'd8;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             start     = 1'b0;
	logic             busy;
	sample_t          sample    = '0;
	logic             done;
	result_t          result;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0]      cfg_data  = '0;

	octave_noise_sum dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.sample    (sample),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	sample_t              pending_samples[$];
	result_t              expected_heights[$];
	logic [CFG_IDX_W-1:0] write_idx_q[$];
	logic [31:0]          write_data_q[$];
	logic signed [31:0]   reg_mirror [8];
	result_t              want;
	int                   idle_pct = 34;
	int                   mismatch_count = 0;
	int                   accepted_count = 0;
	int                   clipped_count = 0;
	int                   programme_count = 0;
	int                   drain_wait;

	function automatic void mirror_reset();
		reg_mirror[REG_SCALE_X]     = 32'sd65536;
		reg_mirror[REG_SCALE_Y]     = 32'sd65536;
		reg_mirror[REG_OFFSET_X]    = 32'sd0;
		reg_mirror[REG_OFFSET_Y]    = 32'sd0;
		reg_mirror[REG_BASE_HEIGHT] = 32'sd0;
		reg_mirror[REG_FIRST_AMP]   = 32'sd65536;
		reg_mirror[REG_PERSISTENCE] = 32'sd32768;
		reg_mirror[REG_OCTAVES]     = 32'sd1;
	endfunction

	function automatic void mirror_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
		case (idx)
			REG_SCALE_X, REG_SCALE_Y, REG_OFFSET_X, REG_OFFSET_Y,
			REG_BASE_HEIGHT, REG_FIRST_AMP: reg_mirror[idx] = data;
			REG_PERSISTENCE: reg_mirror[idx] = {15'd0, data[16:0]};
			REG_OCTAVES: reg_mirror[idx] = {28'd0, data[3:0]};
			default: ;
		endcase
	endfunction

	// integer part of a Q32.32 coordinate after the octave shift, toward zero
	function automatic logic [31:0] lattice_trunc(longint v, int s);
		logic [63:0] u;
		logic [63:0] q;
		u = v;
		if (v < 0) begin
			q = (64'd0 - u) >> s;
			q = 64'd0 - q;
		end else begin
			q = u >> s;
		end
		return q[31:0];
	endfunction

	function automatic logic [31:0] lattice_hash(logic [31:0] x, logic [31:0] y);
		logic [31:0] n;
		logic [31:0] m;
		logic [31:0] v;
		n = x + y * 32'd57;
		m = (n << 13) ^ n;
		v = m * (m * m * 32'd15731 + 32'd789221) + 32'd1376312589;
		return {1'b0, v[30:0]};
	endfunction

	function automatic result_t predict_height(sample_t s);
		longint sx, sy, acc, amp, pers, noise, h;
		int oct;
		logic [31:0] ix, iy;
		result_t r;
		sx = longint'(s.pos_x) * longint'(reg_mirror[REG_SCALE_X])
			+ longint'(reg_mirror[REG_OFFSET_X]) * 65536;
		sy = longint'(s.pos_y) * longint'(reg_mirror[REG_SCALE_Y])
			+ longint'(reg_mirror[REG_OFFSET_Y]) * 65536;
		acc = longint'(reg_mirror[REG_BASE_HEIGHT]);
		amp = longint'(reg_mirror[REG_FIRST_AMP]);
		pers = longint'(reg_mirror[REG_PERSISTENCE]);
		if (pers > 65536)
			pers = 65536;
		oct = reg_mirror[REG_OCTAVES];
		if (oct > MAX_OCTAVES)
			oct = MAX_OCTAVES;
		for (int k = 0; k < oct; k++) begin
			ix = lattice_trunc(sx, 32 - k);
			iy = lattice_trunc(sy, 32 - k);
			h = 0;
			h[31:0] = lattice_hash(ix, iy);
			noise = 64'sd1073741824 - h;
			acc += (noise * amp) >>> 30;
			amp = (amp * pers) >>> 16;
		end
		r.clipped = 1'b0;
		if (acc > 64'sd2147483647) begin
			acc = 64'sd2147483647;
			r.clipped = 1'b1;
		end else if (acc < -64'sd2147483648) begin
			acc = -64'sd2147483648;
			r.clipped = 1'b1;
		end
		r.height = acc[31:0];
		return r;
	endfunction

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 7))
			0: return 32'h0000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h8000_0000;
			3: return 32'hffff_ffff;
			4, 5: return 32'($urandom_range(0, 262143)) - 32'd131072;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] rand_persistence();
		case ($urandom_range(0, 5))
			0: return 32'd0;
			1: return 32'd65536;
			2: return $urandom;
			default: return 32'($urandom_range(0, 65536));
		endcase
	endfunction

	function automatic logic [31:0] rand_octaves();
		logic [3:0] nib;
		if ($urandom_range(0, 4) == 0)
			nib = 4'($urandom_range(0, 15));
		else
			nib = 4'($urandom_range(1, 8));
		return ($urandom & 32'hffff_fff0) | {28'd0, nib};
	endfunction

	function automatic void queue_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
		write_idx_q.push_back(idx);
		write_data_q.push_back(data);
	endfunction

	function automatic void push_sample(logic [31:0] x, logic [31:0] y);
		sample_t s;
		s.pos_x = x;
		s.pos_y = y;
		pending_samples.push_back(s);
	endfunction

	task automatic wait_drained();
		@(negedge clk);
		while (pending_samples.size() != 0 || expected_heights.size() != 0)
			@(negedge clk);
	endtask

	// back-to-back write transfers; valid only drops after the last one
	task automatic apply_reg_writes();
		@(posedge clk);
		while (write_idx_q.size() != 0) begin
			cfg_valid <= 1'b1;
			cfg_index <= write_idx_q[0];
			cfg_data  <= write_data_q[0];
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
			mirror_write(write_idx_q.pop_front(), write_data_q.pop_front());
		end
		cfg_valid <= 1'b0;
		programme_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				expected_heights.push_back(predict_height(sample));
				void'(pending_samples.pop_front());
				accepted_count++;
			end
			if (start && busy) begin
				start <= 1'b1;
			end else if (pending_samples.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
				start  <= 1'b1;
				sample <= pending_samples[0];
			end else begin
				start <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && done === 1'b1) begin
			if (expected_heights.size() == 0) begin
				$display("%0t: unexpected result, expected none, got height %h clipped %b",
					$time, result.height, result.clipped);
				mismatch_count++;
			end else begin
				want = expected_heights.pop_front();
				if (result.clipped === 1'b1)
					clipped_count++;
				if (result.height !== want.height) begin
					$display("%0t: height expected %h got %h", $time, want.height, result.height);
					mismatch_count++;
				end
				if (result.clipped !== want.clipped) begin
					$display("%0t: clipped expected %b got %b", $time, want.clipped,
						result.clipped);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		#3000000;
		$display("Mismatches found");
		$finish;
	end

	initial begin
		mirror_reset();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings, coordinate extremes
		@(negedge clk);
		push_sample(32'h0000_0000, 32'h0000_0000);
		push_sample(32'h7fff_ffff, 32'h8000_0000);
		push_sample(32'h8000_0000, 32'h7fff_ffff);
		push_sample(32'hffff_ffff, 32'h0000_0001);
		push_sample(32'h0001_0000, 32'h0001_8000);

		// huge coordinates wrap, persistence and octave count above limit, top clip
		wait_drained();
		queue_write(REG_SCALE_X, 32'h7fff_ffff);
		queue_write(REG_SCALE_Y, 32'h8000_0000);
		queue_write(REG_OFFSET_X, 32'h7fff_ffff);
		queue_write(REG_OFFSET_Y, 32'h8000_0000);
		queue_write(REG_BASE_HEIGHT, 32'h7fff_ffff);
		queue_write(REG_FIRST_AMP, 32'h7fff_ffff);
		queue_write(REG_PERSISTENCE, 32'hffff_ffff);
		queue_write(REG_OCTAVES, 32'hffff_ffff);
		apply_reg_writes();
		@(negedge clk);
		push_sample(32'h7fff_ffff, 32'h7fff_ffff);
		push_sample(32'h8000_0000, 32'h8000_0000);
		push_sample(32'h0000_0000, 32'h0000_0000);
		push_sample(32'h1234_5678, 32'hedcb_a987);

		// most negative amplitude, full octaves, bottom clip
		wait_drained();
		queue_write(REG_BASE_HEIGHT, 32'h8000_0000);
		queue_write(REG_FIRST_AMP, 32'h8000_0000);
		queue_write(REG_PERSISTENCE, 32'h0001_0000);
		queue_write(REG_OCTAVES, 32'd8);
		apply_reg_writes();
		@(negedge clk);
		push_sample(32'h0000_0000, 32'h0000_0000);
		push_sample(32'h7fff_ffff, 32'h8000_0000);
		push_sample(32'h0000_0001, 32'hffff_ffff);

		// zero octaves, unused indexes ignored
		wait_drained();
		queue_write(REG_OCTAVES, 32'hffff_fff0);
		queue_write(REG_PERSISTENCE, 32'h0000_0000);
		queue_write(REG_FIRST_UNUSED, 32'hffff_ffff);
		queue_write(REG_FIRST_UNUSED + 4'd7, 32'h0000_0000);
		queue_write(REG_SCALE_X, 32'h0000_0001);
		apply_reg_writes();
		@(negedge clk);
		push_sample(32'h7fff_ffff, 32'h0000_0000);
		push_sample(32'h8000_0000, 32'hffff_ffff);
		push_sample(32'h5555_aaaa, 32'haaaa_5555);

		// persistence just above one, octave count one past the limit
		wait_drained();
		queue_write(REG_SCALE_X, 32'h0001_0000);
		queue_write(REG_SCALE_Y, 32'h0001_0000);
		queue_write(REG_OFFSET_X, 32'h0000_0000);
		queue_write(REG_OFFSET_Y, 32'h0000_0000);
		queue_write(REG_BASE_HEIGHT, 32'h0000_0000);
		queue_write(REG_FIRST_AMP, 32'h0001_0000);
		queue_write(REG_PERSISTENCE, 32'd65537);
		queue_write(REG_OCTAVES, 32'd9);
		apply_reg_writes();
		@(negedge clk);
		push_sample(32'h0003_8000, 32'hfffc_8000);
		push_sample(32'h0100_0000, 32'h0000_0000);
		push_sample(32'hffff_0000, 32'h0001_0000);

		for (int ph = 0; ph < 16; ph++) begin
			wait_drained();
			queue_write(REG_SCALE_X, rand_word());
			queue_write(REG_SCALE_Y, rand_word());
			queue_write(REG_OFFSET_X, rand_word());
			queue_write(REG_OFFSET_Y, rand_word());
			queue_write(REG_BASE_HEIGHT, rand_word());
			queue_write(REG_FIRST_AMP, rand_word());
			queue_write(REG_PERSISTENCE, rand_persistence());
			queue_write(REG_OCTAVES, rand_octaves());
			if ($urandom_range(0, 2) == 0)
				queue_write(REG_FIRST_UNUSED + 4'($urandom_range(0, 7)), $urandom);
			apply_reg_writes();
			idle_pct = (ph < 6) ? 34 : (ph < 11) ? 58 : 0;
			@(negedge clk);
			repeat (100)
				push_sample(rand_word(), rand_word());
		end

		drain_wait = 0;
		while ((pending_samples.size() != 0 || expected_heights.size() != 0)
				&& drain_wait < 100000) begin
			@(negedge clk);
			drain_wait++;
		end
		repeat (30) @(negedge clk);
		if (expected_heights.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time,
				expected_heights.size());
			mismatch_count += expected_heights.size();
		end

		$display("Run covered %0d samples over %0d register programmes, %0d saturated heights",
			accepted_count, programme_count, clipped_count);
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

`default_nettype wire
